// ===== hdl/usc_pkg.sv =====
`default_nettype none
package usc_pkg;

  localparam int unsigned LineLen = 64;
  localparam int unsigned IdxW = $clog2(LineLen);
  localparam int unsigned CntW = $clog2(LineLen) + 1;

  localparam logic [7:0] ChBs = 8'h08;
  localparam logic [7:0] ChDel = 8'h7F;
  localparam logic [7:0] ChCr = 8'h0D;
  localparam logic [7:0] ChLf = 8'h0A;
  localparam logic [7:0] ChSp = 8'h20;

  localparam logic [15:0] RateMin = 16'd1000;
  localparam logic [15:0] RateMax = 16'd39000;
  localparam logic [15:0] RateRst = 16'd10000;
  localparam logic [15:0] DriveRst = 16'd500;
  localparam logic [15:0] PauseRst = 16'd50;
  localparam logic [19:0] MagSat = 20'd1000000;

  typedef enum logic [3:0] {
    CMD_NONE = 4'd0,
    CMD_ON = 4'd1,
    CMD_RUN = 4'd2,
    CMD_OFF = 4'd3,
    CMD_CLEAR = 4'd4,
    CMD_FREQ = 4'd5,
    CMD_MSTEP = 4'd6,
    CMD_MSTEP_ERR = 4'd7,
    CMD_UNKNOWN = 4'd8
  } cmd_e;

  typedef enum logic [1:0] {
    MODE_STOP = 2'd0,
    MODE_RUN = 2'd1,
    MODE_AUTO = 2'd2
  } mode_e;

  localparam logic REG_DRIVE = 1'b0;
  localparam logic REG_PAUSE = 1'b1;

  // Controller to datapath.
  typedef struct packed {
    logic       store_wr;
    logic       scan_start;
    logic       scan_step;
    logic       exec;
    logic       tick;
    logic       cnt_inc;
    logic       cnt_dec;
    logic       cnt_clr;
    logic       code_clr;
  } dp_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic       cnt_zero;
    logic       cnt_full;
    logic       scan_done;
    logic       tick_done;
  } dp_sts_t;

endpackage
`default_nettype wire

// ===== hdl/uart_stepper_command_controller.sv =====
`default_nettype none
// Stepper command controller with a serial line editor.
// The input stream carries one item per transaction: tuser is the kind
// (0 received byte, 1 one-millisecond tick) and tdata the byte.
// Each item yields one result, or three for a backspace on a non-empty
// line (backspace, space, backspace); tlast marks the final one.
// Configuration writes set drive_ticks (index 0) and pause_ticks (index 1).
// A plain byte has its first result in the cycle after acceptance, a tick
// once the auto phase sequencer, if active, has finished its update. A line
// end scans the stored line character by character through the single read
// port of the line RAM, waiting for each read, and then decodes it.
// One item is processed at a time; the input is not ready until the last
// result of the previous item has been taken.
// Reset clears the line, stops the motor, disables the driver and restores
// the default rate, microstep pins and timing registers.
// When the receiver stalls, the result holds steady until taken.
module uart_stepper_command_controller
  import usc_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // rx_byte
  input  wire logic        s_axis_tuser,   // kind
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [39:0]      m_axis_tdata,   // echo_valid, echo_byte, command,
                                           // step_active, driver_enable_n, direction,
                                           // ms1, ms2, step_freq_hz, zero fill
  output logic             m_axis_tlast,   // last
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_idx_i,
  input  wire logic [15:0] cfg_data_i
);
  dp_cmd_t    cmd;
  dp_sts_t    sts;
  logic [7:0] ch, eb;
  logic       ev;
  logic [3:0] code;
  logic       sa, en_n, dir, ms1, ms2;
  logic [15:0] rate;

  usc_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .kind_i(s_axis_tuser), .ch_i(s_axis_tdata), .ch_o(ch),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .echo_valid_o(ev), .echo_byte_o(eb), .last_o(m_axis_tlast),
    .cmd_o(cmd), .sts_i(sts)
  );

  usc_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts), .ch_i(ch),
    .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .cmd_code_o(code), .step_active_o(sa), .driver_enable_n_o(en_n),
    .direction_o(dir), .ms1_o(ms1), .ms2_o(ms2), .step_freq_hz_o(rate)
  );

  assign m_axis_tdata = {6'd0, rate, ms2, ms1, dir, en_n, sa, code, eb, ev};
endmodule
`default_nettype wire

// ===== hdl/usc_ram.sv =====
`default_nettype none
module usc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

// ===== hdl/usc_datapath.sv =====
`default_nettype none
module usc_datapath
  import usc_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire dp_cmd_t    cmd_i,
  output dp_sts_t         sts_o,
  input  wire logic [7:0] ch_i,
  input  wire logic       cfg_we_i,
  input  wire logic       cfg_idx_i,
  input  wire logic [15:0] cfg_data_i,
  output logic [3:0]      cmd_code_o,
  output logic            step_active_o,
  output logic            driver_enable_n_o,
  output logic            direction_o,
  output logic            ms1_o,
  output logic            ms2_o,
  output logic [15:0]     step_freq_hz_o
);
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [CntW-1:0] pos_q, pos_d;
  logic [7:0]  rdata;
  logic [IdxW-1:0] raddr;
  logic        rvalid_q;
  logic [15:0] drive_q, pause_q;
  mode_e       mode_q, mode_d;
  logic [1:0]  phase_q, phase_d;
  logic [15:0] timer_q, timer_d;
  logic        dir_q, dir_d, pul_q, pul_d, en_q, en_d;
  logic [1:0]  ms_q, ms_d;
  logic [15:0] rate_q, rate_d;
  logic [3:0]  code_q, code_d;
  logic [2:0]  guard_q, guard_d;
  logic        tick_busy_q, tick_busy_d;
  // Scan state.
  logic        m_on_q, m_run_q, m_off_q, m_clr_q, m_on_d, m_run_d, m_off_d, m_clr_d;
  logic [7:0]  first_q, first_d;
  logic [1:0]  ps_q, ps_d; // 0 skip, 1 digits, 2 stopped
  logic        neg_q, neg_d;
  logic [19:0] mag_q, mag_d;
  logic [23:0] mag_x10;
  logic        scanning_q, scanning_d;

  usc_ram #(.Width(8), .Depth(LineLen)) u_ram (
    .clk_i,
    .we_i   (cmd_i.store_wr),
    .waddr_i(cnt_q[IdxW-1:0]),
    .wdata_i(ch_i),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  assign raddr = pos_q[IdxW-1:0];
  assign mag_x10 = {1'b0, mag_q, 3'b000} + {3'b000, mag_q, 1'b0} + {16'd0, rdata - 8'h30};

  function automatic logic [7:0] word_ch(input logic [2:0] w, input logic [CntW-1:0] p);
    logic [39:0] s;
    begin
      case (w)
        3'd0: s = {24'd0, "no"};
        3'd1: s = {16'd0, "nur"};
        3'd2: s = {16'd0, "ffo"};
        default: s = "raelc";
      endcase
      word_ch = (p < CntW'(5)) ? s[p[2:0]*8 +: 8] : 8'h00;
    end
  endfunction

  always_comb begin
    cnt_d = cnt_q;
    if (cmd_i.cnt_clr) cnt_d = '0;
    else if (cmd_i.cnt_inc) cnt_d = cnt_q + 1'b1;
    else if (cmd_i.cnt_dec) cnt_d = cnt_q - 1'b1;
  end

  always_comb begin
    pos_d = pos_q; scanning_d = scanning_q;
    m_on_d = m_on_q; m_run_d = m_run_q; m_off_d = m_off_q; m_clr_d = m_clr_q;
    first_d = first_q; ps_d = ps_q; neg_d = neg_q; mag_d = mag_q;
    if (cmd_i.scan_start) begin
      pos_d = '0; scanning_d = 1'b1;
      m_on_d = (cnt_q == CntW'(2)); m_run_d = (cnt_q == CntW'(3));
      m_off_d = (cnt_q == CntW'(3)); m_clr_d = (cnt_q == CntW'(5));
      ps_d = 2'd0; neg_d = 1'b0; mag_d = '0;
    end else if (cmd_i.scan_step && rvalid_q) begin
      if (rdata != word_ch(3'd0, pos_q)) m_on_d = 1'b0;
      if (rdata != word_ch(3'd1, pos_q)) m_run_d = 1'b0;
      if (rdata != word_ch(3'd2, pos_q)) m_off_d = 1'b0;
      if (rdata != word_ch(3'd3, pos_q)) m_clr_d = 1'b0;
      if (pos_q == '0) begin
        first_d = rdata;
      end else begin
        unique case (ps_q)
          2'd0: begin
            if (rdata == 8'h20 || rdata == 8'h09 || rdata == 8'h0B || rdata == 8'h0C) ps_d = 2'd0;
            else if (rdata == 8'h2B || rdata == 8'h2D) begin
              neg_d = (rdata == 8'h2D); ps_d = 2'd1;
            end else if (rdata >= 8'h30 && rdata <= 8'h39) begin
              mag_d = (mag_x10 > {4'd0, MagSat}) ? MagSat : mag_x10[19:0]; ps_d = 2'd1;
            end else ps_d = 2'd2;
          end
          2'd1: begin
            if (rdata >= 8'h30 && rdata <= 8'h39)
              mag_d = (mag_x10 > {4'd0, MagSat}) ? MagSat : mag_x10[19:0];
            else ps_d = 2'd2;
          end
          default: ps_d = 2'd2;
        endcase
      end
      pos_d = pos_q + 1'b1;
      if (pos_q + 1'b1 == cnt_q) scanning_d = 1'b0;
    end
  end

  assign sts_o.cnt_zero = (cnt_q == '0);
  assign sts_o.cnt_full = (cnt_q >= CntW'(LineLen - 1));
  assign sts_o.scan_done = !scanning_q;
  assign sts_o.tick_done = !tick_busy_q;

  always_comb begin
    mode_d = mode_q; phase_d = phase_q; timer_d = timer_q; dir_d = dir_q;
    pul_d = pul_q; en_d = en_q; ms_d = ms_q; rate_d = rate_q; code_d = code_q;
    guard_d = guard_q; tick_busy_d = tick_busy_q;
    if (cmd_i.exec) begin
      if (m_on_q) begin
        code_d = CMD_ON;
        if (mode_q != MODE_AUTO) begin
          mode_d = MODE_AUTO; phase_d = 2'd0; timer_d = '0;
        end
      end else if (m_run_q) begin
        code_d = CMD_RUN; mode_d = MODE_RUN; dir_d = 1'b0; en_d = 1'b0; pul_d = 1'b1;
      end else if (m_off_q) begin
        code_d = CMD_OFF; mode_d = MODE_STOP; pul_d = 1'b0; en_d = 1'b1;
      end else if (m_clr_q) begin
        code_d = CMD_CLEAR;
      end else if (first_q == 8'h66) begin
        code_d = CMD_FREQ;
        if (neg_q && mag_q != '0) rate_d = RateMax;
        else if (mag_q == '0) rate_d = RateMin;
        else if (mag_q >= 20'd39) rate_d = RateMax;
        else rate_d = 16'(mag_q[5:0] * 16'd1000);
      end else if (first_q == 8'h73) begin
        code_d = CMD_MSTEP_ERR;
        if (!(neg_q && mag_q != '0)) begin
          case (mag_q)
            20'd8:  begin ms_d = 2'd0; code_d = CMD_MSTEP; end
            20'd16: begin ms_d = 2'd1; code_d = CMD_MSTEP; end
            20'd32: begin ms_d = 2'd2; code_d = CMD_MSTEP; end
            20'd64: begin ms_d = 2'd3; code_d = CMD_MSTEP; end
            default: ;
          endcase
        end
      end else code_d = CMD_UNKNOWN;
    end else if (cmd_i.code_clr) begin
      code_d = CMD_NONE;
    end
    if (cmd_i.tick) begin
      guard_d = '0; tick_busy_d = (mode_q == MODE_AUTO);
    end else if (tick_busy_q) begin
      // One loop iteration of the phase sequencer per cycle.
      if (timer_q == '0) begin
        if (!phase_q[0]) begin
          dir_d = phase_q[1]; en_d = 1'b0; pul_d = 1'b1;
          timer_d = (drive_q == '0) ? 16'd1 : drive_q;
          tick_busy_d = 1'b0;
          timer_d = timer_d - 1'b1;
          if (timer_d == '0) phase_d = phase_q + 1'b1;
        end else begin
          pul_d = 1'b0; en_d = 1'b1;
          if (pause_q == '0) begin
            phase_d = phase_q + 1'b1; guard_d = guard_q + 1'b1;
            if (guard_q == 3'd3) tick_busy_d = 1'b0;
          end else begin
            timer_d = pause_q - 1'b1; tick_busy_d = 1'b0;
            if (timer_d == '0) phase_d = phase_q + 1'b1;
          end
        end
      end else begin
        timer_d = timer_q - 1'b1; tick_busy_d = 1'b0;
        if (timer_d == '0) phase_d = phase_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0; pos_q <= '0; rvalid_q <= 1'b0; scanning_q <= 1'b0;
      drive_q <= DriveRst; pause_q <= PauseRst;
      mode_q <= MODE_STOP; phase_q <= '0; timer_q <= '0;
      dir_q <= 1'b0; pul_q <= 1'b0; en_q <= 1'b1; ms_q <= 2'd2; rate_q <= RateRst;
      code_q <= CMD_NONE; guard_q <= '0; tick_busy_q <= 1'b0;
      m_on_q <= 1'b0; m_run_q <= 1'b0; m_off_q <= 1'b0; m_clr_q <= 1'b0;
      first_q <= '0; ps_q <= '0; neg_q <= 1'b0; mag_q <= '0;
    end else begin
      cnt_q <= cnt_d; pos_q <= pos_d; scanning_q <= scanning_d;
      // Read data is valid in the cycle after its address; a step waits for each read.
      rvalid_q <= cmd_i.scan_step && scanning_q && !rvalid_q;
      if (cfg_we_i) begin
        if (cfg_idx_i == REG_DRIVE) drive_q <= cfg_data_i;
        else pause_q <= cfg_data_i;
      end
      mode_q <= mode_d; phase_q <= phase_d; timer_q <= timer_d;
      dir_q <= dir_d; pul_q <= pul_d; en_q <= en_d; ms_q <= ms_d; rate_q <= rate_d;
      code_q <= code_d; guard_q <= guard_d; tick_busy_q <= tick_busy_d;
      m_on_q <= m_on_d; m_run_q <= m_run_d; m_off_q <= m_off_d; m_clr_q <= m_clr_d;
      first_q <= first_d; ps_q <= ps_d; neg_q <= neg_d; mag_q <= mag_d;
    end
  end

  assign cmd_code_o = code_q;
  assign step_active_o = pul_q;
  assign driver_enable_n_o = en_q;
  assign direction_o = dir_q;
  assign ms1_o = ms_q[0];
  assign ms2_o = ms_q[1];
  assign step_freq_hz_o = rate_q;
endmodule
`default_nettype wire

// ===== hdl/usc_ctrl.sv =====
`default_nettype none
module usc_ctrl
  import usc_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic       kind_i,
  input  wire logic [7:0] ch_i,
  output logic [7:0]      ch_o,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic            echo_valid_o,
  output logic [7:0]      echo_byte_o,
  output logic            last_o,
  output dp_cmd_t         cmd_o,
  input  wire dp_sts_t    sts_i
);
  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_SCAN = 6'b000010,
    S_EXEC = 6'b000100,
    S_TICK = 6'b001000,
    S_EMIT = 6'b010000,
    S_BS   = 6'b100000
  } state_e;

  state_e      state_q, state_d;
  logic        ev_q, ev_d, last_q, last_d;
  logic [7:0]  eb_q, eb_d;
  logic [1:0]  bs_q, bs_d;
  logic        acc;

  assign acc = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == S_IDLE);
  assign ch_o = ch_i;

  always_comb begin
    state_d = state_q; ev_d = ev_q; eb_d = eb_q; last_d = last_q; bs_d = bs_q;
    cmd_o = '0;
    unique case (state_q)
      S_IDLE: begin
        if (acc) begin
          cmd_o.code_clr = 1'b1;
          if (kind_i) begin
            cmd_o.tick = 1'b1; ev_d = 1'b0; eb_d = '0; last_d = 1'b1;
            state_d = S_TICK;
          end else if (ch_i == ChBs || ch_i == ChDel) begin
            if (sts_i.cnt_zero) begin
              ev_d = 1'b0; eb_d = '0; last_d = 1'b1; state_d = S_EMIT;
            end else begin
              cmd_o.cnt_dec = 1'b1; ev_d = 1'b1; eb_d = ChBs; last_d = 1'b0;
              bs_d = 2'd0; state_d = S_BS;
            end
          end else if (ch_i == ChCr || ch_i == ChLf) begin
            ev_d = 1'b1; eb_d = ch_i; last_d = 1'b1;
            cmd_o.scan_start = 1'b1;
            state_d = sts_i.cnt_zero ? S_EMIT : S_SCAN;
          end else begin
            if (!sts_i.cnt_full) begin
              cmd_o.store_wr = 1'b1; cmd_o.cnt_inc = 1'b1;
            end
            ev_d = 1'b1; eb_d = ch_i; last_d = 1'b1;
            state_d = S_EMIT;
          end
        end
      end
      S_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (sts_i.scan_done) state_d = S_EXEC;
      end
      S_EXEC: begin
        cmd_o.exec = 1'b1; cmd_o.cnt_clr = 1'b1; state_d = S_EMIT;
      end
      S_TICK: begin
        if (sts_i.tick_done) state_d = S_EMIT;
      end
      S_EMIT: begin
        if (out_ready_i) state_d = S_IDLE;
      end
      S_BS: begin
        if (out_ready_i) begin
          bs_d = bs_q + 1'b1;
          unique case (bs_q)
            2'd0: eb_d = ChSp;
            default: begin eb_d = ChBs; last_d = 1'b1; state_d = S_EMIT; end
          endcase
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign out_valid_o = (state_q == S_EMIT) || (state_q == S_BS);
  assign echo_valid_o = ev_q;
  assign echo_byte_o = eb_q;
  assign last_o = last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; bs_q <= '0; ev_q <= 1'b0; last_q <= 1'b0;
    end else begin
      state_q <= state_d; bs_q <= bs_d; ev_q <= ev_d; last_q <= last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    eb_q <= eb_d;
  end
endmodule
`default_nettype wire
